@@ rtl/dual_stepper_step_sequencer_unit_assert.svh @@
// Assertion macros for the step sequencer.
`ifndef DUAL_STEPPER_STEP_SEQUENCER_UNIT_ASSERT_SVH
`define DUAL_STEPPER_STEP_SEQUENCER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define DSS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Plain invariant, sampled on clk, idle during reset.
`define DSS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

@@ rtl/dss_pkg.sv @@
package dss_pkg;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_MOVE = 2'd1;
	localparam logic [1:0] OP_HOME = 2'd2;

	localparam logic [1:0] REG_HOLD    = 2'd0;
	localparam logic [1:0] REG_STEPW   = 2'd1;
	localparam logic [1:0] REG_STARTW  = 2'd2;
	localparam logic [1:0] REG_SCALE   = 2'd3;

	localparam logic [2:0] PH_STEP          = 3'd0;
	localparam logic [2:0] PH_WAIT_DACS_OFF = 3'd1;
	localparam logic [2:0] PH_WAIT_DAC_ON   = 3'd2;
	localparam logic [2:0] PH_STARTUP       = 3'd3;
	localparam logic [2:0] PH_HOLD          = 3'd4;
	localparam logic [2:0] PH_BACKOFF       = 3'd5;

	localparam logic [15:0] HOLD_RST   = 16'd16;
	localparam logic [15:0] STEPW_RST  = 16'd1024;
	localparam logic [23:0] STARTW_RST = 24'd65536;
	localparam logic [3:0]  SCALE_RST  = 4'd4;

	typedef struct packed {
		logic [15:0] hold;
		logic [15:0] step_wait;
		logic [23:0] startup_wait;
		logic [3:0]  scale;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  phase;
		logic [31:0] wait_cnt;
		logic [31:0] target;
		logic [31:0] position;
		logic [3:0]  expo;
		logic        active;
		logic        dirn;
		logic        step_pin;
		logic        dir_pin;
		logic        wake_pin;
		logic        dac_en;
	} motor_t;

endpackage

@@ rtl/dss_motor.sv @@
module dss_motor
	import dss_pkg::*;
(
	input  cfg_t   cfg,
	input  motor_t own,
	input  motor_t oth,
	input  logic   own_dac_act,
	input  logic   any_dac_act,
	output motor_t own_nxt,
	output motor_t oth_nxt
);

	logic neg;
	logic done;

	assign neg  = own.target[31];
	assign done = (own.wait_cnt <= 32'd1);

	always_comb begin
		own_nxt = own;
		oth_nxt = oth;
		case (own.phase)
			PH_STEP: begin
				if (own.target != 32'd0) begin
					if (!own.active) begin
						// start only once the other motor is fully idle
						if (oth.target == 32'd0 && oth.phase == PH_STEP) begin
							own_nxt.dir_pin  = neg;
							own_nxt.expo     = cfg.scale;
							own_nxt.dirn     = neg;
							own_nxt.wake_pin = 1'b0;
							own_nxt.dac_en   = 1'b0;
							own_nxt.active   = 1'b0;
							oth_nxt.wake_pin = 1'b0;
							oth_nxt.dac_en   = 1'b0;
							oth_nxt.active   = 1'b0;
							own_nxt.phase    = PH_WAIT_DACS_OFF;
						end
					end else begin
						if (own.dirn != neg) begin
							own_nxt.dir_pin = neg;
							own_nxt.expo    = cfg.scale;
							own_nxt.dirn    = neg;
						end
						if (neg) begin
							own_nxt.target   = own.target + 32'd1;
							own_nxt.position = own.position - 32'd1;
						end else begin
							own_nxt.target   = own.target - 32'd1;
							own_nxt.position = own.position + 32'd1;
						end
						own_nxt.step_pin = 1'b1;
						own_nxt.wait_cnt = {16'd0, cfg.hold};
						own_nxt.phase    = PH_HOLD;
					end
				end
			end
			PH_WAIT_DACS_OFF: begin
				if (!any_dac_act) begin
					own_nxt.dac_en = 1'b1;
					own_nxt.phase  = PH_WAIT_DAC_ON;
				end
			end
			PH_WAIT_DAC_ON: begin
				if (own_dac_act) begin
					own_nxt.wake_pin = 1'b1;
					own_nxt.wait_cnt = {8'd0, cfg.startup_wait};
					own_nxt.phase    = PH_STARTUP;
				end
			end
			PH_STARTUP: begin
				if (done) begin
					own_nxt.wait_cnt = 32'd0;
					own_nxt.active   = 1'b1;
					own_nxt.phase    = PH_STEP;
				end else begin
					own_nxt.wait_cnt = own.wait_cnt - 32'd1;
				end
			end
			PH_HOLD: begin
				if (done) begin
					own_nxt.step_pin = 1'b0;
					own_nxt.wait_cnt = {16'd0, cfg.step_wait} << own.expo;
					if (own.expo != 4'd0) begin
						own_nxt.expo = own.expo - 4'd1;
					end
					own_nxt.phase = PH_BACKOFF;
				end else begin
					own_nxt.wait_cnt = own.wait_cnt - 32'd1;
				end
			end
			PH_BACKOFF: begin
				if (done) begin
					own_nxt.wait_cnt = 32'd0;
					own_nxt.phase    = PH_STEP;
				end else begin
					own_nxt.wait_cnt = own.wait_cnt - 32'd1;
				end
			end
			default: begin
				own_nxt.phase = PH_STEP;
			end
		endcase
	end

endmodule

@@ rtl/dual_stepper_step_sequencer_unit.sv @@
// Channel   Handshake              Payload
// cmd       cmd_valid/cmd_ready    opcode, motor_sel, steps, dac_active_0/1
// res       res_valid/res_ready    step/dir/wake/dac_enable per motor, ready_0/1,
//                                  home_reached
// cfg       cfg_we (no wait)       cfg_addr, cfg_wdata
//
// One item per cycle sustained while results drain; each item goes from the
// input register through both motor machines into the result register.
// The critical path is the 32-bit wait counter compare and decrement of motor 0
// feeding motor 1 in the same cycle.
// arst_n clears all motor state (pin fields too), valids and loads the register defaults.
// A stalled result holds both registers; cmd_ready drops only while the input
// register is full and the result register cannot drain.
module dual_stepper_step_sequencer_unit
	import dss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [23:0] cfg_wdata,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  opcode,
	input  logic        motor_sel,
	input  logic signed [31:0] steps,
	input  logic        dac_active_0,
	input  logic        dac_active_1,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        step_out_0,
	output logic        step_out_1,
	output logic        dir_out_0,
	output logic        dir_out_1,
	output logic        wake_out_0,
	output logic        wake_out_1,
	output logic        dac_enable_0,
	output logic        dac_enable_1,
	output logic        ready_0,
	output logic        ready_1,
	output logic        home_reached
);

`include "dual_stepper_step_sequencer_unit_assert.svh"

	cfg_t        cfg_q;
	motor_t      m0_q, m1_q;
	logic        init_q;

	// input register
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic        sel_s1;
	logic [31:0] steps_s1;
	logic [1:0]  dac_s1;

	logic        advance;
	logic        any_dac;
	motor_t      a0, a1, b0, b1;
	motor_t      m0_nxt, m1_nxt;
	logic        init_nxt;
	logic        home_nxt;
	logic [31:0] home_pos;

	assign advance   = !res_valid || res_ready;
	assign cmd_ready = !valid_s1 || advance;
	assign any_dac   = dac_s1[0] | dac_s1[1];

	// register writes; the user must write only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold         <= HOLD_RST;
			cfg_q.step_wait    <= STEPW_RST;
			cfg_q.startup_wait <= STARTW_RST;
			cfg_q.scale        <= SCALE_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_HOLD:   cfg_q.hold         <= cfg_wdata[15:0];
				REG_STEPW:  cfg_q.step_wait    <= cfg_wdata[15:0];
				REG_STARTW: cfg_q.startup_wait <= cfg_wdata;
				REG_SCALE:  cfg_q.scale        <= cfg_wdata[3:0];
				default:    cfg_q.scale        <= cfg_q.scale;
			endcase
		end
	end

	// capture an item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			op_s1    <= opcode;
			sel_s1   <= motor_sel;
			steps_s1 <= steps;
			dac_s1   <= {dac_active_1, dac_active_0};
		end
	end

	// motor 0 runs first, motor 1 sees its effect in the same tick
	dss_motor u_motor0 (
		.cfg         (cfg_q),
		.own         (m0_q),
		.oth         (m1_q),
		.own_dac_act (dac_s1[0]),
		.any_dac_act (any_dac),
		.own_nxt     (a0),
		.oth_nxt     (a1)
	);

	dss_motor u_motor1 (
		.cfg         (cfg_q),
		.own         (a1),
		.oth         (a0),
		.own_dac_act (dac_s1[1]),
		.any_dac_act (any_dac),
		.own_nxt     (b1),
		.oth_nxt     (b0)
	);

	assign home_pos = sel_s1 ? m1_q.position : m0_q.position;

	always_comb begin
		m0_nxt   = m0_q;
		m1_nxt   = m1_q;
		init_nxt = init_q;
		home_nxt = 1'b0;
		case (op_s1)
			OP_TICK: begin
				if (!init_q) begin
					// first tick only drives step, dir and wake low
					m0_nxt.step_pin = 1'b0;
					m0_nxt.dir_pin  = 1'b0;
					m0_nxt.wake_pin = 1'b0;
					m1_nxt.step_pin = 1'b0;
					m1_nxt.dir_pin  = 1'b0;
					m1_nxt.wake_pin = 1'b0;
					init_nxt        = 1'b1;
				end else begin
					m0_nxt = b0;
					m1_nxt = b1;
				end
			end
			OP_MOVE: begin
				if (sel_s1) begin
					m1_nxt.target = steps_s1;
				end else begin
					m0_nxt.target = steps_s1;
				end
			end
			OP_HOME: begin
				if (sel_s1) begin
					m1_nxt.target = 32'd0 - home_pos;
				end else begin
					m0_nxt.target = 32'd0 - home_pos;
				end
				home_nxt = (home_pos == 32'd0);
			end
			default: begin
				// unused code: leave state alone
				home_nxt = 1'b0;
			end
		endcase
	end

	// commit state when the item moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m0_q   <= '0;
			m1_q   <= '0;
			init_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			m0_q   <= m0_nxt;
			m1_q   <= m1_nxt;
			init_q <= init_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (advance) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			step_out_0   <= m0_nxt.step_pin;
			step_out_1   <= m1_nxt.step_pin;
			dir_out_0    <= m0_nxt.dir_pin;
			dir_out_1    <= m1_nxt.dir_pin;
			wake_out_0   <= m0_nxt.wake_pin;
			wake_out_1   <= m1_nxt.wake_pin;
			dac_enable_0 <= m0_nxt.dac_en;
			dac_enable_1 <= m1_nxt.dac_en;
			ready_0      <= (m0_nxt.target == 32'd0);
			ready_1      <= (m1_nxt.target == 32'd0);
			home_reached <= home_nxt;
		end
	end

	// only one driver may be awake at a time
	`DSS_ASSERT_ALWAYS(a_one_awake, !(m0_q.wake_pin && m1_q.wake_pin), "both drivers awake")
	// a step pulse is high only during the hold phase
	`DSS_ASSERT_IMPL(a_step_hold0, m0_q.step_pin, m0_q.phase == PH_HOLD, "motor 0 step outside hold")
	`DSS_ASSERT_IMPL(a_step_hold1, m1_q.step_pin, m1_q.phase == PH_HOLD, "motor 1 step outside hold")
	// an awake motor 0 driver is running or still in its startup wait
	`DSS_ASSERT_IMPL(a_wake_state0, m0_q.wake_pin, m0_q.active || m0_q.phase == PH_STARTUP,
		"motor 0 awake while not started")

endmodule

@@ dv/tb.sv @@
module tb import dss_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// Opcode 3 has no name in the package; the block must leave all state alone.
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int RESET_CYCLES = 12;
	localparam int DRAIN_CYCLES = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PRESSURE_AFTER = 200;
	localparam int PRESSURE_CYCLES = 90;

	typedef struct packed {
		logic [1:0]  opcode;
		logic        sel;
		logic [31:0] steps;
		logic [1:0]  dac;	// bit m is dac_active_m
	} cmd_item_t;

	// Pin levels seen on the result channel; vectors are indexed by motor.
	typedef struct packed {
		logic [1:0] step;
		logic [1:0] dir;
		logic [1:0] wake;
		logic [1:0] dac_en;
		logic [1:0] rdy;
		logic       home;
	} pin_result_t;

	typedef struct packed {
		cfg_t          cfg;
		logic          primed;
		motor_t [1:0]  mot;
	} seq_state_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [23:0] cfg_wdata = '0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	logic [1:0] opcode = '0;
	logic motor_sel = 1'b0;
	logic signed [31:0] steps = '0;
	logic dac_active_0 = 1'b0;
	logic dac_active_1 = 1'b0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic step_out_0, step_out_1, dir_out_0, dir_out_1;
	logic wake_out_0, wake_out_1, dac_enable_0, dac_enable_1;
	logic ready_0, ready_1, home_reached;

	// seq_model tracks what the block must produce; plan_model runs ahead while
	// items are queued, so the emulated DACs can answer the enables in a sane way.
	seq_state_t seq_model;
	seq_state_t plan_model;
	cmd_item_t pending_cmds[$];
	pin_result_t expected_pins[$];
	cmd_item_t cur_cmd;
	pin_result_t next_pins;
	pin_result_t want;
	int mismatches = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	dual_stepper_step_sequencer_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.opcode       (opcode),
		.motor_sel    (motor_sel),
		.steps        (steps),
		.dac_active_0 (dac_active_0),
		.dac_active_1 (dac_active_1),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.step_out_0   (step_out_0),
		.step_out_1   (step_out_1),
		.dir_out_0    (dir_out_0),
		.dir_out_1    (dir_out_1),
		.wake_out_0   (wake_out_0),
		.wake_out_1   (wake_out_1),
		.dac_enable_0 (dac_enable_0),
		.dac_enable_1 (dac_enable_1),
		.ready_0      (ready_0),
		.ready_1      (ready_1),
		.home_reached (home_reached)
	);

	// ------------------------------------------------------------------
	// Sequencer prediction
	// ------------------------------------------------------------------

	function automatic seq_state_t reset_state();
		seq_state_t s;
		s = '0;
		s.cfg.hold = HOLD_RST;
		s.cfg.step_wait = STEPW_RST;
		s.cfg.startup_wait = STARTW_RST;
		s.cfg.scale = SCALE_RST;
		return s;
	endfunction

	// Count one tick off a wait; a count of zero or one ends it on this tick.
	function automatic logic count_out(inout logic [31:0] cnt);
		if (cnt <= 32'd1) begin
			cnt = '0;
			return 1'b1;
		end
		cnt = cnt - 32'd1;
		return 1'b0;
	endfunction

	// One pass of motor m's machine. Motor 1 runs after motor 0 in the same tick,
	// so it sees whatever motor 0 just changed (power-down included).
	function automatic void run_motor(inout seq_state_t s, input int m, input logic [1:0] dac);
		motor_t me;
		motor_t oth;
		logic neg;
		me = s.mot[m];
		oth = s.mot[1 - m];
		neg = me.target[31];
		case (me.phase)
			PH_STEP: begin
				if (me.target != '0) begin
					if (!me.active) begin
						// Claim the drivers only once the other motor is idle.
						if (oth.target == '0 && oth.phase == PH_STEP) begin
							me.dir_pin = neg;
							me.expo = s.cfg.scale;
							me.dirn = neg;
							me.wake_pin = 1'b0;
							oth.wake_pin = 1'b0;
							me.dac_en = 1'b0;
							oth.dac_en = 1'b0;
							me.active = 1'b0;
							oth.active = 1'b0;
							me.phase = PH_WAIT_DACS_OFF;
						end
					end else begin
						// A reversal restarts the ramp from cfg.scale.
						if (me.dirn != neg) begin
							me.dir_pin = neg;
							me.expo = s.cfg.scale;
							me.dirn = neg;
						end
						if (neg) begin
							me.target = me.target + 32'd1;
							me.position = me.position - 32'd1;
						end else begin
							me.target = me.target - 32'd1;
							me.position = me.position + 32'd1;
						end
						me.step_pin = 1'b1;
						me.wait_cnt = {16'd0, s.cfg.hold};
						me.phase = PH_HOLD;
					end
				end
			end
			PH_WAIT_DACS_OFF: begin
				if (dac == 2'b00) begin
					me.dac_en = 1'b1;
					me.phase = PH_WAIT_DAC_ON;
				end
			end
			PH_WAIT_DAC_ON: begin
				if (dac[m]) begin
					me.wake_pin = 1'b1;
					me.wait_cnt = {8'd0, s.cfg.startup_wait};
					me.phase = PH_STARTUP;
				end
			end
			PH_STARTUP: begin
				if (count_out(me.wait_cnt)) begin
					me.active = 1'b1;
					me.phase = PH_STEP;
				end
			end
			PH_HOLD: begin
				if (count_out(me.wait_cnt)) begin
					me.step_pin = 1'b0;
					me.wait_cnt = {16'd0, s.cfg.step_wait} << me.expo;
					if (me.expo != '0)
						me.expo = me.expo - 4'd1;
					me.phase = PH_BACKOFF;
				end
			end
			PH_BACKOFF: begin
				if (count_out(me.wait_cnt))
					me.phase = PH_STEP;
			end
			default: me.phase = PH_STEP;
		endcase
		s.mot[m] = me;
		s.mot[1 - m] = oth;
	endfunction

	// Apply one command item and return the pin levels it leaves behind.
	function automatic pin_result_t apply_cmd(inout seq_state_t s, input cmd_item_t c);
		pin_result_t r;
		logic at_home;
		at_home = 1'b0;
		case (c.opcode)
			OP_TICK: begin
				if (!s.primed) begin
					// First tick only parks the step, dir and wake pins low.
					for (int m = 0; m < 2; m++) begin
						s.mot[m].step_pin = 1'b0;
						s.mot[m].dir_pin = 1'b0;
						s.mot[m].wake_pin = 1'b0;
					end
					s.primed = 1'b1;
				end else begin
					run_motor(s, 0, c.dac);
					run_motor(s, 1, c.dac);
				end
			end
			OP_MOVE: s.mot[c.sel].target = c.steps;
			OP_HOME: begin
				at_home = (s.mot[c.sel].position == '0);
				s.mot[c.sel].target = 32'd0 - s.mot[c.sel].position;
			end
			default: ;
		endcase
		for (int m = 0; m < 2; m++) begin
			r.step[m] = s.mot[m].step_pin;
			r.dir[m] = s.mot[m].dir_pin;
			r.wake[m] = s.mot[m].wake_pin;
			r.dac_en[m] = s.mot[m].dac_en;
			r.rdy[m] = (s.mot[m].target == '0);
		end
		r.home = at_home;
		return r;
	endfunction

	function automatic void check_bit(string name, logic exp_v, logic got);
		if (got !== exp_v) begin
			$error("%s: expected %0b, got %0b", name, exp_v, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building
	// ------------------------------------------------------------------

	// Queue one item and run it through the planning copy right away.
	task automatic push_cmd(logic [1:0] op, logic sel, logic [31:0] val, logic [1:0] dac);
		cmd_item_t c;
		pin_result_t unused;
		c.opcode = op;
		c.sel = sel;
		c.steps = val;
		c.dac = dac;
		pending_cmds.push_back(c);
		unused = apply_cmd(plan_model, c);
	endtask

	// Emulated DACs report whatever enable level they last saw; now and then
	// they report noise instead.
	function automatic logic [1:0] follow_dac();
		if ($urandom_range(0, 9) == 0)
			return 2'($urandom());
		return {plan_model.mot[1].dac_en, plan_model.mot[0].dac_en};
	endfunction

	task automatic push_tick();
		push_cmd(OP_TICK, 1'($urandom()), $urandom(), follow_dac());
	endtask

	function automatic logic [31:0] short_move();
		logic [31:0] n;
		n = 32'($urandom_range(1, 6));
		return $urandom_range(0, 1) ? 32'd0 - n : n;
	endfunction

	task automatic random_cmds(int count);
		int pick;
		logic sel;
		@(negedge clk);
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			sel = 1'($urandom());
			if (pick < 72)
				push_tick();
			else if (pick < 84)
				push_cmd(OP_MOVE, sel, short_move(), 2'($urandom()));
			else if (pick < 88)
				push_cmd(OP_MOVE, sel, $urandom(), 2'($urandom()));
			else if (pick < 94)
				push_cmd(OP_HOME, sel, $urandom(), 2'($urandom()));
			else if (pick < 97)
				push_cmd(OP_MOVE, sel, 32'd0, 2'($urandom()));
			else
				push_cmd(OP_SPARE, sel, $urandom(), 2'($urandom()));
		end
	endtask

	// Write all four registers on consecutive edges; both models follow.
	task automatic load_regs(logic [15:0] hold, logic [15:0] step_wait,
			logic [23:0] startup_wait, logic [3:0] scale);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= REG_HOLD;
		cfg_wdata <= {8'd0, hold};
		@(posedge clk);
		cfg_addr <= REG_STEPW;
		cfg_wdata <= {8'd0, step_wait};
		@(posedge clk);
		cfg_addr <= REG_STARTW;
		cfg_wdata <= startup_wait;
		@(posedge clk);
		cfg_addr <= REG_SCALE;
		cfg_wdata <= {20'd0, scale};
		@(posedge clk);
		cfg_we <= 1'b0;
		seq_model.cfg.hold = hold;
		seq_model.cfg.step_wait = step_wait;
		seq_model.cfg.startup_wait = startup_wait;
		seq_model.cfg.scale = scale;
		plan_model.cfg = seq_model.cfg;
	endtask

	// Wait until every queued item went in and every result came back, then let the
	// pipeline drain before touching registers.
	task automatic settle();
		while (pending_cmds.size() != 0 || cmd_valid || expected_pins.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Command driver: bursts of random length with random gaps between them
	// ------------------------------------------------------------------

	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			// Predict at acceptance; the prediction waits in a queue for the item's result.
			if (cmd_valid && cmd_ready) begin
				next_pins = apply_cmd(seq_model, cur_cmd);
				expected_pins.push_back(next_pins);
			end
			// Hold the payload while the item is still being offered.
			if (!cmd_valid || cmd_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					cmd_valid <= 1'b0;
				end else if (pending_cmds.size() != 0) begin
					cur_cmd = pending_cmds.pop_front();
					opcode <= cur_cmd.opcode;
					motor_sel <= cur_cmd.sel;
					steps <= cur_cmd.steps;
					dac_active_0 <= cur_cmd.dac[0];
					dac_active_1 <= cur_cmd.dac[1];
					cmd_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: stall pattern plus one long hold-off to back up the block
	// ------------------------------------------------------------------

	int res_count = 0;
	int hold_off = 0;
	int pat_age = 0;
	bit pressured = 1'b0;
	logic [7:0] ready_pat = 8'hFF;

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready)
				res_count++;
			if (hold_off > 0) begin
				hold_off--;
				res_ready <= 1'b0;
			end else if (!pressured && res_count >= PRESSURE_AFTER && cmd_valid) begin
				// Starve the output while the sender keeps offering items.
				pressured = 1'b1;
				hold_off = PRESSURE_CYCLES;
				res_ready <= 1'b0;
			end else begin
				if (pat_age == 0) begin
					pat_age = $urandom_range(16, 96);
					case ($urandom_range(0, 2))
						0: ready_pat = 8'hFF;
						1: ready_pat = 8'($urandom());
						default: ready_pat = ~(8'd1 << $urandom_range(0, 7));
					endcase
					if (ready_pat == '0)
						ready_pat = 8'h01;
				end
				pat_age--;
				res_ready <= ready_pat[0];
				ready_pat = {ready_pat[0], ready_pat[7:1]};
			end
		end
	end

	// Compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			if (expected_pins.size() == 0) begin
				$error("result item arrived with no command outstanding");
				mismatches++;
			end else begin
				want = expected_pins.pop_front();
				check_bit("step_out_0", want.step[0], step_out_0);
				check_bit("step_out_1", want.step[1], step_out_1);
				check_bit("dir_out_0", want.dir[0], dir_out_0);
				check_bit("dir_out_1", want.dir[1], dir_out_1);
				check_bit("wake_out_0", want.wake[0], wake_out_0);
				check_bit("wake_out_1", want.wake[1], wake_out_1);
				check_bit("dac_enable_0", want.dac_en[0], dac_enable_0);
				check_bit("dac_enable_1", want.dac_en[1], dac_enable_1);
				check_bit("ready_0", want.rdy[0], ready_0);
				check_bit("ready_1", want.rdy[1], ready_1);
				check_bit("home_reached", want.home, home_reached);
			end
		end
	end

	// Watchdog: end the run if neither channel moves an item for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL dual_stepper_step_sequencer_unit");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------

	initial begin
		seq_model = reset_state();
		plan_model = reset_state();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Short counts first so the motors actually step; the reset counts would
		// park a motor in its startup wait for the rest of the run.
		load_regs(16'd1, 16'd1, 24'd1, 4'd0);

		@(negedge clk);
		// Commands ahead of the first tick change only the target.
		push_cmd(OP_MOVE, 1'b0, 32'd3, 2'b00);
		push_cmd(OP_HOME, 1'b1, 32'hFFFF_FFFF, 2'b11);	// position zero: home flag set
		push_cmd(OP_SPARE, 1'b1, 32'h5A5A_A5A5, 2'b10);	// unused opcode: no change
		push_cmd(OP_TICK, 1'b0, 32'd0, 2'b11);	// first tick: pins parked low
		push_cmd(OP_TICK, 1'b1, 32'd0, 2'b11);	// motor 0 claims, powers all down
		push_cmd(OP_TICK, 1'b0, 32'd0, 2'b11);	// DACs still active: hold
		push_cmd(OP_TICK, 1'b0, 32'd0, 2'b00);	// both off: enable DAC 0
		push_cmd(OP_MOVE, 1'b1, 32'hFFFF_FFFE, 2'b00);	// motor 1 must wait its turn
		push_cmd(OP_TICK, 1'b0, 32'd0, 2'b10);	// only the other DAC is up: hold
		push_cmd(OP_TICK, 1'b0, 32'd0, 2'b01);	// DAC 0 up: wake motor 0
		repeat (4) push_tick();
		push_cmd(OP_MOVE, 1'b0, 32'hFFFF_FFFD, 2'b01);	// reverse while running
		repeat (4) push_tick();
		push_cmd(OP_MOVE, 1'b0, 32'h7FFF_FFFF, 2'b00);
		push_cmd(OP_MOVE, 1'b0, 32'h8000_0000, 2'b11);
		push_tick();
		push_cmd(OP_HOME, 1'b0, 32'd0, 2'b00);	// position away from zero
		repeat (2) push_tick();
		settle();

		random_cmds(150);
		settle();

		load_regs(16'd2, 16'd1, 24'd3, 4'd2);
		random_cmds(150);
		settle();

		// Zero counts behave as one.
		load_regs(16'd0, 16'd0, 24'd0, 4'd1);
		random_cmds(100);
		settle();

		load_regs(16'd3, 16'd2, 24'd5, 4'd3);
		random_cmds(150);
		settle();

		load_regs(16'($urandom_range(1, 4)), 16'($urandom_range(1, 3)),
			24'($urandom_range(1, 8)), 4'($urandom_range(0, 3)));
		random_cmds(120);
		settle();

		// Largest settings last: once loaded, these waits outlast the run.
		load_regs(16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 4'hF);
		random_cmds(50);
		settle();

		if (mismatches == 0)
			$display("PASS dual_stepper_step_sequencer_unit");
		else
			$display("FAIL dual_stepper_step_sequencer_unit");
		$finish;
	end

endmodule
